// ===== rtl/c3x3_pkg.sv =====
package c3x3_pkg;

  localparam int IN_CHANNELS_DEF  = 4;
  localparam int OUT_CHANNELS_DEF = 4;
  localparam int MAX_WIDTH_DEF    = 256;

  localparam int PIX_CH  = 4;
  localparam int CH_W    = 16;
  localparam int PIX_W   = PIX_CH * CH_W;
  localparam int OCH_W   = 32;
  localparam int TAPS    = 9;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int PROD_W  = 32;
  localparam int PSUM_W  = 36;
  localparam int ACC_W   = 40;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = PIX_CH * OCH_W;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_PIXEL       = 2'd2,
    OP_PAD_TICK    = 2'd3
  } op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } mac_ctl_t;

  function automatic logic signed [PROD_W-1:0] mul16(input logic [CH_W-1:0] a,
                                                     input logic [CH_W-1:0] b);
    logic signed [PROD_W-1:0] ea;
    logic signed [PROD_W-1:0] eb;
    ea = {{(PROD_W-CH_W){a[CH_W-1]}}, a};
    eb = {{(PROD_W-CH_W){b[CH_W-1]}}, b};
    return ea * eb;
  endfunction

endpackage

// ===== rtl/c3x3_ram.sv =====
module c3x3_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/c3x3_mac.sv =====
module c3x3_mac #(
  parameter int IN_CHANNELS  = c3x3_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = c3x3_pkg::OUT_CHANNELS_DEF,
  localparam int USED_IN  = (IN_CHANNELS < c3x3_pkg::PIX_CH) ? IN_CHANNELS : c3x3_pkg::PIX_CH,
  localparam int USED_OUT = (OUT_CHANNELS < c3x3_pkg::PIX_CH) ? OUT_CHANNELS : c3x3_pkg::PIX_CH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  c3x3_pkg::mac_ctl_t                     in_ctl,
  input  c3x3_pkg::win_t                         in_win,
  input  logic [USED_OUT-1:0][USED_IN-1:0][c3x3_pkg::TAPS-1:0][c3x3_pkg::CH_W-1:0] weights,
  input  logic [USED_OUT-1:0][c3x3_pkg::CH_W-1:0] bias,
  output logic                                   in_ready,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [c3x3_pkg::OUT_DATA_W-1:0]        out_tdata,   // out_channel_0..3
  output logic                                   out_tlast    // frame_end
);

  logic ld3, ld4, ld_out;
  logic v3_r, v4_r, out_v_r;
  logic last3_r, last4_r, out_last_r;
  logic [USED_OUT-1:0][USED_IN-1:0][c3x3_pkg::TAPS-1:0][c3x3_pkg::PROD_W-1:0] prod_r;
  logic [USED_OUT-1:0][USED_IN-1:0][c3x3_pkg::PSUM_W-1:0] psum_r;
  logic [USED_OUT-1:0][c3x3_pkg::CH_W-1:0] bias3_r, bias4_r;
  logic [USED_OUT-1:0][USED_IN-1:0][c3x3_pkg::PSUM_W-1:0] psum_nxt;
  logic [c3x3_pkg::PIX_CH-1:0][c3x3_pkg::OCH_W-1:0] out_nxt, out_data_r;

  assign ld_out   = !out_v_r || out_tready;
  assign ld4      = !v4_r || ld_out;
  assign ld3      = !v3_r || ld4;
  assign in_ready = ld3;

  always_comb begin
    for (int o = 0; o < USED_OUT; o++) begin
      for (int i = 0; i < USED_IN; i++) begin
        psum_nxt[o][i] = '0;
        for (int t = 0; t < c3x3_pkg::TAPS; t++) begin
          psum_nxt[o][i] = psum_nxt[o][i] + {{(c3x3_pkg::PSUM_W-c3x3_pkg::PROD_W)
                                              {prod_r[o][i][t][c3x3_pkg::PROD_W-1]}},
                                             prod_r[o][i][t]};
        end
      end
    end
  end

  always_comb begin
    logic signed [c3x3_pkg::ACC_W-1:0] acc;
    out_nxt = '0;
    for (int o = 0; o < USED_OUT; o++) begin
      acc = {{(c3x3_pkg::ACC_W-c3x3_pkg::CH_W-8){bias4_r[o][c3x3_pkg::CH_W-1]}},
             bias4_r[o], 8'd0};
      for (int i = 0; i < USED_IN; i++) begin
        acc = acc + {{(c3x3_pkg::ACC_W-c3x3_pkg::PSUM_W){psum_r[o][i][c3x3_pkg::PSUM_W-1]}},
                     psum_r[o][i]};
      end
      if (acc > 40'sd2147483647) begin
        out_nxt[o] = 32'h7fff_ffff;
      end else if (acc < -40'sd2147483648) begin
        out_nxt[o] = 32'h8000_0000;
      end else begin
        out_nxt[o] = acc[c3x3_pkg::OCH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld3) begin
        v3_r <= in_ctl.valid;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (ld_out) begin
        out_v_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && in_ctl.valid) begin
      last3_r <= in_ctl.frame_end;
      bias3_r <= bias;
      for (int o = 0; o < USED_OUT; o++) begin
        for (int i = 0; i < USED_IN; i++) begin
          for (int t = 0; t < c3x3_pkg::TAPS; t++) begin
            prod_r[o][i][t] <= c3x3_pkg::mul16(in_win[t][i*c3x3_pkg::CH_W +: c3x3_pkg::CH_W],
                                               weights[o][i][t]);
          end
        end
      end
    end
    if (ld4 && v3_r) begin
      last4_r <= last3_r;
      bias4_r <= bias3_r;
      psum_r  <= psum_nxt;
    end
    if (ld_out && v4_r) begin
      out_last_r <= last4_r;
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(out_data_r)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !ld4) |=> v4_r)
    else $error("stalled sum stage lost its item");

endmodule

// ===== rtl/conv3x3_same_pad_stream.sv =====
// pipeline: stage 1, stage 2, then the MAC product, sum and output registers feed out_
// throughput: one input transaction per cycle unless out_tready stalls; a pixel in the last
//   column of a row holds the input back while a second, padding column shifts in
// reset: rst_n synchronous, active low; clears counters and pipeline valids,
//   width and height go to 256; line memory is not swept, rows not yet filled are masked
module conv3x3_same_pad_stream #(
  parameter int IN_CHANNELS  = c3x3_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = c3x3_pkg::OUT_CHANNELS_DEF,
  parameter int MAX_WIDTH    = c3x3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [c3x3_pkg::IN_DATA_W-1:0]    in_tdata,   // index, coef, channel_0..3
  input  logic [1:0]                        in_tuser,   // op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [c3x3_pkg::OUT_DATA_W-1:0]   out_tdata,  // out_channel_0..3
  output logic                              out_tlast,  // frame_end
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [c3x3_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int USED_IN  = (IN_CHANNELS < c3x3_pkg::PIX_CH) ? IN_CHANNELS : c3x3_pkg::PIX_CH;
  localparam int USED_OUT = (OUT_CHANNELS < c3x3_pkg::PIX_CH) ? OUT_CHANNELS : c3x3_pkg::PIX_CH;
  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int PW       = c3x3_pkg::PIX_W;
  localparam int CW       = c3x3_pkg::COL_W;
  localparam int RW       = c3x3_pkg::ROW_W;

  typedef enum logic [2:0] {
    K_NONE, K_WEIGHT, K_BIAS, K_PIXEL, K_TICK
  } kind_t;

  logic [c3x3_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0] col_r, w_eff;
  logic [RW-1:0] row_r, h_eff;

  c3x3_pkg::op_t            in_op;
  logic [c3x3_pkg::IDX_W-1:0] in_idx;
  logic [c3x3_pkg::CH_W-1:0]  in_coef;
  logic [PW-1:0]            in_pix;
  logic                     accept;
  kind_t                    kind_nxt;
  logic                     first_nxt, lastcol_nxt, emit_nxt, last_nxt, ge1_nxt, ge2_nxt;
  logic                     inr_nxt;
  logic [CW-1:0]            col_nxt, xcol;
  logic [RW-1:0]            row_nxt;

  logic                     s1_v_r, s1_tail_r, s1_first_r, s1_lastcol_r, s1_emit_r;
  logic                     s1_last_r, s1_ge1_r, s1_ge2_r, s1_inr_r;
  kind_t                    s1_kind_r;
  logic [PW-1:0]            s1_pix_r;
  logic [AW-1:0]            s1_x_r;
  logic [c3x3_pkg::IDX_W-1:0] s1_idx_r;
  logic [c3x3_pkg::CH_W-1:0]  s1_coef_r;
  logic                     byp_hit_r;
  logic [2*PW-1:0]          byp_data_r;

  logic [2*PW-1:0]          ram_rdata, line;
  logic                     ram_we;
  logic [2*PW-1:0]          ram_wdata;
  logic [2:0][PW-1:0]       newcol;
  c3x3_pkg::win_t           win_r, win_nxt, s2_win_r;
  logic                     emit_now, shift_now, s1_take, convert, s1_free;
  logic                     s2_v_r, s2_last_r, ld2, mac_ready;
  c3x3_pkg::mac_ctl_t       s2_ctl;

  logic [USED_OUT-1:0][USED_IN-1:0][c3x3_pkg::TAPS-1:0][c3x3_pkg::CH_W-1:0] weight_r;
  logic [USED_OUT-1:0][c3x3_pkg::CH_W-1:0] bias_r;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_r);
    end
    h_eff = (height_r == '0) ? RW'(1) : height_r;
  end

  assign in_op   = c3x3_pkg::op_t'(in_tuser);
  assign in_idx  = in_tdata[7:0];
  assign in_coef = in_tdata[23:8];

  always_comb begin
    in_pix = '0;
    for (int c = 0; c < USED_IN; c++) begin
      in_pix[c*c3x3_pkg::CH_W +: c3x3_pkg::CH_W] = in_tdata[24 + c*c3x3_pkg::CH_W +: c3x3_pkg::CH_W];
    end
  end

  // classify the incoming transaction against the counters
  always_comb begin
    kind_nxt    = K_NONE;
    first_nxt   = 1'b0;
    lastcol_nxt = 1'b0;
    emit_nxt    = 1'b0;
    last_nxt    = 1'b0;
    ge1_nxt     = 1'b0;
    ge2_nxt     = 1'b0;
    inr_nxt     = 1'b0;
    col_nxt     = col_r;
    row_nxt     = row_r;
    xcol        = col_r;
    case (in_op)
      c3x3_pkg::OP_LOAD_WEIGHT: kind_nxt = K_WEIGHT;
      c3x3_pkg::OP_LOAD_BIAS:   kind_nxt = K_BIAS;
      c3x3_pkg::OP_PIXEL: begin
        if (row_r < h_eff) begin
          kind_nxt    = K_PIXEL;
          first_nxt   = (col_r == '0);
          lastcol_nxt = ({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, w_eff};
          emit_nxt    = (row_r != '0) && (col_r != '0);
          ge1_nxt     = (row_r != '0);
          ge2_nxt     = (row_r >= RW'(2));
          inr_nxt     = 1'b1;
          if (lastcol_nxt) begin
            col_nxt = '0;
            row_nxt = row_r + RW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      c3x3_pkg::OP_PAD_TICK: begin
        if (row_r >= h_eff) begin
          kind_nxt = K_TICK;
          inr_nxt  = (col_r != '0) && (col_r <= w_eff);
          emit_nxt = (col_r >= CW'(2));
          last_nxt = ({1'b0, col_r} >= ({1'b0, w_eff} + (CW+1)'(1)));
          ge1_nxt  = 1'b1;
          ge2_nxt  = (h_eff >= RW'(2));
          xcol     = col_r - CW'(1);
          if (last_nxt) begin
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      default: kind_nxt = K_NONE;
    endcase
  end

  // stage 1: line memory data and window shift
  assign line = byp_hit_r ? byp_data_r : ram_rdata;

  always_comb begin
    newcol = '0;
    if (!s1_tail_r && s1_inr_r) begin
      newcol[0] = s1_ge2_r ? line[2*PW-1:PW] : '0;
      newcol[1] = s1_ge1_r ? line[PW-1:0] : '0;
      newcol[2] = s1_pix_r;
    end
    for (int ky = 0; ky < 3; ky++) begin
      if (s1_first_r && !s1_tail_r) begin
        win_nxt[ky*3]     = win_r[ky*3+2];
        win_nxt[ky*3 + 1] = '0;
      end else begin
        win_nxt[ky*3]     = win_r[ky*3+1];
        win_nxt[ky*3 + 1] = win_r[ky*3+2];
      end
      win_nxt[ky*3 + 2] = newcol[ky];
    end
  end

  assign shift_now = (s1_kind_r == K_PIXEL) || (s1_kind_r == K_TICK);
  assign emit_now  = shift_now && (s1_tail_r ? s1_ge1_r : s1_emit_r);
  assign ld2       = !s2_v_r || mac_ready;
  assign s1_take   = s1_v_r && ld2;
  assign convert   = s1_take && (s1_kind_r == K_PIXEL) && s1_lastcol_r && !s1_tail_r;
  assign s1_free   = !s1_v_r || (s1_take && !convert);
  assign in_tready = s1_free;
  assign accept    = in_tvalid && in_tready;

  assign ram_we    = s1_take && (s1_kind_r == K_PIXEL) && !s1_tail_r;
  assign ram_wdata = {line[PW-1:0], s1_pix_r};

  c3x3_ram #(
    .WIDTH (2*PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_x_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (xcol[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= c3x3_pkg::IMAGE_WIDTH_RST;
      height_r  <= c3x3_pkg::IMAGE_HEIGHT_RST;
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s1_tail_r <= 1'b0;
      s1_kind_r <= K_NONE;
      byp_hit_r <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (c3x3_pkg::reg_idx_t'(cfg_index))
          c3x3_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          c3x3_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_v_r    <= 1'b1;
        s1_tail_r <= 1'b0;
        s1_kind_r <= kind_nxt;
        byp_hit_r <= ram_we && (s1_x_r == xcol[AW-1:0]);
      end else if (convert) begin
        s1_tail_r <= 1'b1;
      end else if (s1_take) begin
        s1_v_r    <= 1'b0;
        s1_tail_r <= 1'b0;
        byp_hit_r <= 1'b0;
      end
      if (ld2) begin
        s2_v_r <= s1_take && emit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r   <= first_nxt;
      s1_lastcol_r <= lastcol_nxt;
      s1_emit_r    <= emit_nxt;
      s1_last_r    <= last_nxt;
      s1_ge1_r     <= ge1_nxt;
      s1_ge2_r     <= ge2_nxt;
      s1_inr_r     <= inr_nxt;
      s1_pix_r     <= (kind_nxt == K_PIXEL) ? in_pix : '0;
      s1_x_r       <= xcol[AW-1:0];
      s1_idx_r     <= in_idx;
      s1_coef_r    <= in_coef;
      byp_data_r   <= ram_wdata;
    end
    if (s1_take && shift_now) begin
      win_r <= win_nxt;
    end
    if (ld2 && s1_take && emit_now) begin
      s2_win_r  <= win_nxt;
      s2_last_r <= s1_last_r && !s1_tail_r;
    end
    for (int o = 0; o < USED_OUT; o++) begin
      for (int i = 0; i < USED_IN; i++) begin
        for (int t = 0; t < c3x3_pkg::TAPS; t++) begin
          if (s1_take && (s1_kind_r == K_WEIGHT) &&
              (int'(s1_idx_r) == (o*IN_CHANNELS + i)*c3x3_pkg::TAPS + t)) begin
            weight_r[o][i][t] <= s1_coef_r;
          end
        end
      end
      if (s1_take && (s1_kind_r == K_BIAS) && (int'(s1_idx_r) == o)) begin
        bias_r[o] <= s1_coef_r;
      end
    end
  end

  assign s2_ctl.valid     = s2_v_r;
  assign s2_ctl.frame_end = s2_last_r;

  c3x3_mac #(
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (s2_ctl),
    .in_win     (s2_win_r),
    .weights    (weight_r),
    .bias       (bias_r),
    .in_ready   (mac_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assert property (@(posedge clk) disable iff (!rst_n) s1_tail_r |-> s1_v_r)
    else $error("tail phase without an item");
  assert property (@(posedge clk) disable iff (!rst_n) byp_hit_r |-> s1_v_r)
    else $error("bypass without an item");
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} <= ({1'b0, w_eff} + (CW+1)'(1)))
    else $error("column count beyond padded row");
  assert property (@(posedge clk) disable iff (!rst_n) row_r <= h_eff)
    else $error("row count beyond image");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import c3x3_pkg::*;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] data;
    logic                  frame_end;
  } out_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  conv3x3_same_pad_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // model of the convolution state
  logic [PIX_W-1:0] line_mem[2][MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win[TAPS];
  logic [CH_W-1:0]  wts[IN_CHANNELS_DEF*OUT_CHANNELS_DEF*TAPS];
  logic [CH_W-1:0]  biases[OUT_CHANNELS_DEF];
  int               row_c;
  int               col_c;
  int               img_w;
  int               img_h;

  out_px_t pending_px[$];
  int      mismatches;
  int      results_seen;
  int      frames_seen;
  int      items_sent;
  int      idle_cycles;
  bit      calm;
  int      rx_hold;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_w();
    if (img_w < 1) return 1;
    if (img_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return img_w;
  endfunction

  function automatic int eff_h();
    return (img_h < 1) ? 1 : img_h;
  endfunction

  function automatic out_px_t conv_at_window(bit last);
    out_px_t r;
    longint  acc;
    r.data      = '0;
    r.frame_end = last;
    for (int o = 0; o < OUT_CHANNELS_DEF; o++) begin
      acc = longint'($signed(biases[o])) * 256;
      for (int i = 0; i < IN_CHANNELS_DEF; i++)
        for (int t = 0; t < TAPS; t++)
          acc += longint'($signed(win[t][16*i +: 16])) *
                 longint'($signed(wts[(o*IN_CHANNELS_DEF+i)*TAPS+t]));
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      r.data[32*o +: 32] = acc[31:0];
    end
    return r;
  endfunction

  function automatic void slide_window(int r, int pc, logic [PIX_W-1:0] pix, bit bottom,
                                       bit last);
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    int               x;
    top = '0;
    mid = '0;
    bot = '0;
    if (pc >= 1 && pc <= eff_w()) begin
      x   = (pc - 1) % MAX_WIDTH_DEF;
      top = (r >= 2) ? line_mem[0][x] : '0;
      mid = (r >= 1) ? line_mem[1][x] : '0;
      bot = pix;
      if (!bottom) begin
        line_mem[0][x] = line_mem[1][x];
        line_mem[1][x] = pix;
      end
    end
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    if (r >= 1 && pc >= 2) pending_px.push_back(conv_at_window(last));
  endfunction

  function automatic void model_item(op_t op, logic [7:0] idx, logic [15:0] coef,
                                     logic [PIX_W-1:0] pix);
    int  w;
    bit  last;
    w = eff_w();
    case (op)
      OP_LOAD_WEIGHT: begin
        if (idx < IN_CHANNELS_DEF*OUT_CHANNELS_DEF*TAPS) wts[idx] = coef;
      end
      OP_LOAD_BIAS: begin
        if (idx < OUT_CHANNELS_DEF) biases[idx] = coef;
      end
      OP_PIXEL: begin
        if (row_c < eff_h()) begin
          if (col_c == 0) slide_window(row_c, 0, '0, 1'b0, 1'b0);
          slide_window(row_c, col_c + 1, pix, 1'b0, 1'b0);
          if (col_c + 1 >= w) slide_window(row_c, w + 1, '0, 1'b0, 1'b0);
          col_c++;
          if (col_c >= w) begin
            col_c = 0;
            row_c++;
          end
        end
      end
      default: begin
        if (row_c >= eff_h()) begin
          last = (col_c >= w + 1);
          slide_window(row_c, col_c, '0, 1'b1, last);
          if (last) begin
            row_c = 0;
            col_c = 0;
          end else begin
            col_c++;
          end
        end
      end
    endcase
  endfunction

  task automatic send_item(op_t op, logic [7:0] idx, logic [15:0] coef,
                           logic [PIX_W-1:0] pix);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pix, coef, idx};
    do @(posedge clk); while (!in_tready);
    model_item(op, idx, coef, pix);
    items_sent++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    send_item(OP_PIXEL, 8'($urandom), 16'($urandom), pix);
  endtask

  task automatic send_tick();
    send_item(OP_PAD_TICK, 8'($urandom), 16'($urandom), PIX_W'({$urandom, $urandom}));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == REG_IMAGE_WIDTH) img_w = value & 9'h1ff;
    else img_h = value & 9'h1ff;
    row_c = 0;
    col_c = 0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [PIX_W-1:0] rand_pix(bit narrow);
    logic [PIX_W-1:0] p;
    for (int c = 0; c < PIX_CH; c++)
      p[16*c +: 16] = narrow ? 16'($signed($urandom_range(0, 1023)) - 512) : 16'($urandom);
    return p;
  endfunction

  // full image in raster order, optional noise of ignored ops
  task automatic run_frame(int w, int h, bit narrow, bit noisy);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if (noisy && $urandom_range(0, 9) == 0) send_tick();
        send_pixel(rand_pix(narrow));
      end
    for (int k = 0; k < w + 2; k++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_pixel(rand_pix(narrow));
      send_tick();
    end
  endtask

  task automatic load_coefs(bit narrow);
    for (int k = 0; k < IN_CHANNELS_DEF*OUT_CHANNELS_DEF*TAPS; k++)
      send_item(OP_LOAD_WEIGHT, 8'(k),
                narrow ? 16'($signed($urandom_range(0, 511)) - 256) : 16'($urandom), '0);
    for (int k = 0; k < OUT_CHANNELS_DEF; k++)
      send_item(OP_LOAD_BIAS, 8'(k), 16'($urandom), '0);
  endtask

  task automatic test_coef_load();
    load_coefs(1'b1);
    send_item(OP_LOAD_WEIGHT, 8'd255, 16'hffff, '0);
    send_item(OP_LOAD_WEIGHT, 8'd144, 16'h8000, '0);
    send_item(OP_LOAD_BIAS, 8'd4, 16'h7fff, '0);
    send_item(OP_LOAD_BIAS, 8'd170, 16'h8000, '0);
    send_item(OP_LOAD_BIAS, 8'd0, 16'h8000, '0);
    send_item(OP_LOAD_BIAS, 8'd3, 16'h7fff, '0);
  endtask

  task automatic test_small_frames();
    set_size(1, 1);
    send_pixel({4{16'h8000}});
    send_tick();
    send_tick();
    send_tick();
    set_size(2, 2);
    send_tick();
    send_pixel({4{16'h7fff}});
    send_pixel({16'h0000, 16'hffff, 16'h8000, 16'h7fff});
    send_pixel('0);
    send_pixel({4{16'hffff}});
    for (int k = 0; k < 4; k++) send_tick();
  endtask

  task automatic test_saturation();
    for (int k = 0; k < 36; k++) send_item(OP_LOAD_WEIGHT, 8'(k), 16'h8000, '0);
    for (int k = 36; k < 72; k++) send_item(OP_LOAD_WEIGHT, 8'(k), 16'h7fff, '0);
    set_size(3, 3);
    for (int k = 0; k < 9; k++) send_pixel(k[0] ? {4{16'h8000}} : {4{16'h7fff}});
    send_pixel({4{16'h8000}});
    for (int k = 0; k < 5; k++) send_tick();
  endtask

  task automatic test_register_extremes();
    set_size(0, 0);
    run_frame(1, 1, 1'b0, 1'b1);
    // width above the line memory: one full clamped row, then the start of the next
    set_size(300, 2);
    for (int k = 0; k < MAX_WIDTH_DEF + 3; k++) send_pixel(rand_pix(1'b1));
    set_size(511, 511);
    set_size(5, 4);
    for (int k = 0; k < 7; k++) send_pixel(rand_pix(1'b0));
    set_size(4, 2);
    run_frame(4, 2, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames();
    int w;
    int h;
    bit narrow;
    int start;
    start = items_sent;
    while (items_sent - start < 110) begin
      if (items_sent - start > 80) calm = 1'b1;
      if ($urandom_range(0, 5) == 0) load_coefs($urandom_range(0, 1));
      for (int k = $urandom_range(0, 4); k > 0; k--)
        send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), '0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      narrow = $urandom_range(0, 2) != 0;
      set_size(w, h);
      if ($urandom_range(0, 7) == 0) begin
        for (int k = $urandom_range(1, w * h); k > 0; k--) send_pixel(rand_pix(narrow));
      end else begin
        run_frame(w, h, narrow, $urandom_range(0, 2) == 0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tlast) frames_seen++;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction data=%h last=%b",
                                       out_tdata, out_tlast);
      end else begin
        want = pending_px.pop_front();
        for (int o = 0; o < PIX_CH; o++)
          if (out_tdata[32*o +: 32] !== want.data[32*o +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_channel_%0d: expected %h got %h", o, want.data[32*o +: 32],
                       out_tdata[32*o +: 32]);
          end
        if (out_tlast !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame_end: expected %b got %b", want.frame_end, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("conv3x3_same_pad_stream regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_index    = 1'b0;
    cfg_wdata    = '0;
    out_tready   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    frames_seen  = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    calm         = 1'b0;
    rx_hold      = 0;
    row_c        = 0;
    col_c        = 0;
    img_w        = 256;
    img_h        = 256;
    for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
      line_mem[0][k] = '0;
      line_mem[1][k] = '0;
    end
    for (int k = 0; k < TAPS; k++) win[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_coef_load();
    test_small_frames();
    test_saturation();
    test_register_extremes();
    test_random_frames();

    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d input transactions, checked %0d results over %0d frames",
             items_sent, results_seen, frames_seen);
    $display("covered coefficient loads, padding edges, saturation and size extremes");
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("conv3x3_same_pad_stream regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("conv3x3_same_pad_stream regression: fail");
    end
    $finish;
  end

endmodule
